// ===== hdl/tbpf_pkg.sv =====
package tbpf_pkg;

    // Field and state widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int STATE_WIDTH  = 32;

    // Coefficient format: Q2.17
    localparam int COEF_FRAC = 17;
    localparam int FB1_W     = 20;
    localparam int FB2_W     = 18;
    localparam int GAIN_W    = 19;
    localparam int COEF_W    = FB1_W;   // widest coefficient, signed multiplier operand

    // Datapath widths
    localparam int PROD_W = COEF_W + STATE_WIDTH;   // one product
    localparam int ACC_W  = PROD_W + 1;             // sum of two products
    localparam int RND_W  = ACC_W - COEF_FRAC;      // rounded feedback sum
    localparam int TSUM_W = RND_W + 1;              // plus input sample
    localparam int ORND_W = PROD_W - COEF_FRAC;     // rounded output product

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FB1_W;

    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_TWO = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = CFG_IDX_W'(2);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(131072);

    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [STATE_WIDTH-1:0] state_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

endpackage

// ===== hdl/tbpf_mul.sv =====
module tbpf_mul
    import tbpf_pkg::*;
(
    input  logic  clk,
    input  coef_t coef,
    input  state_t operand,
    output prod_t product
);

    prod_t product_reg;

    // Register the signed product of the selected operands
    always_ff @(posedge clk)
    begin
        product_reg <= prod_t'(coef) * prod_t'(operand);
    end

    assign product = product_reg;

endmodule

// ===== hdl/two_pole_bandpass_filter_unit.sv =====
// Channel   Handshake                 Payload
// input     in_valid / in_ready       sample_in  (signed Q1.15)
// output    out_valid / out_ready     sample_out (signed Q1.15, saturated)
// config    cfg_write (no handshake)  cfg_index, cfg_data
//
// Each sample passes through the sequencer from acceptance to a loaded output register:
// three products on the one shared 20x32 multiplier, a rounding and add step,
// and an output step. in_ready is high only while the sequencer is idle,
// so a new sample is not accepted until the last one has left the output step.
// A full output register that is not taken holds the sequencer in its output step.
// Reset clears both delay words and the feedback coefficients, and sets the gain to 1.0.
module two_pole_bandpass_filter_unit
    import tbpf_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input  logic                           cfg_write,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_MUL3 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (COEF_FRAC - 1);

    logic [2:0]                     state_reg, state_next;
    logic signed [FB1_W-1:0]        fb1_reg;
    logic signed [FB2_W-1:0]        fb2_reg;
    logic [GAIN_W-1:0]              gain_reg;
    state_t                         delay_one_reg, delay_two_reg;
    state_t                         t_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;

    coef_t                          mul_coef;
    state_t                         mul_operand;
    prod_t                          product;

    logic signed [ACC_W-1:0]        fb_sum;
    logic signed [RND_W-1:0]        fb_rnd;
    logic signed [TSUM_W-1:0]       t_sum;
    state_t                         t_next;
    logic signed [PROD_W-1:0]       out_sum;
    logic signed [ORND_W-1:0]       out_rnd;
    logic signed [SAMPLE_WIDTH-1:0] out_next;
    logic                           in_beat;
    logic                           out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample_out = out_data_reg;

    // Select multiplier operands for the current step; hold the gain product while
    // the output step waits
    always_comb
    begin
        mul_coef    = coef_t'(fb1_reg);
        mul_operand = delay_one_reg;
        unique case (state_reg)
            S_MUL2:
            begin
                mul_coef    = coef_t'(fb2_reg);
                mul_operand = delay_two_reg;
            end
            S_MUL3, S_OUT:
            begin
                mul_coef    = coef_t'({1'b0, gain_reg});
                mul_operand = t_reg;
            end
            default:
            begin
                mul_coef    = coef_t'(fb1_reg);
                mul_operand = delay_one_reg;
            end
        endcase
    end

    tbpf_mul u_mul
    (
        .clk     (clk),
        .coef    (mul_coef),
        .operand (mul_operand),
        .product (product)
    );

    // Round the feedback sum once, add the sample, saturate to state width
    always_comb
    begin
        fb_sum = acc_reg + {product[PROD_W-1], product} + ACC_HALF;
        fb_rnd = fb_sum[ACC_W-1:COEF_FRAC];
        t_sum  = {fb_rnd[RND_W-1], fb_rnd}
               + {{(TSUM_W-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};
        if ((t_sum[TSUM_W-1:STATE_WIDTH-1] == '0) || (t_sum[TSUM_W-1:STATE_WIDTH-1] == '1))
        begin
            t_next = t_sum[STATE_WIDTH-1:0];
        end
        else if (t_sum[TSUM_W-1])
        begin
            t_next = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end
        else
        begin
            t_next = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
    end

    // Round the gain product, saturate to sample width
    always_comb
    begin
        out_sum = product + PROD_HALF;
        out_rnd = out_sum[PROD_W-1:COEF_FRAC];
        if ((out_rnd[ORND_W-1:SAMPLE_WIDTH-1] == '0) || (out_rnd[ORND_W-1:SAMPLE_WIDTH-1] == '1))
        begin
            out_next = out_rnd[SAMPLE_WIDTH-1:0];
        end
        else if (out_rnd[ORND_W-1])
        begin
            out_next = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            out_next = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_beat) state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_SUM;
            S_SUM:  state_next = S_MUL3;
            S_MUL3: state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, coefficients and delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fb1_reg       <= '0;
            fb2_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FEEDBACK_ONE: fb1_reg  <= cfg_data[FB1_W-1:0];
                    REG_FEEDBACK_TWO: fb2_reg  <= cfg_data[FB2_W-1:0];
                    REG_OUTPUT_GAIN:  gain_reg <= cfg_data[GAIN_W-1:0];
                    default:          ;
                endcase
            end
            if (state_reg == S_SUM)
            begin
                delay_two_reg <= delay_one_reg;
                delay_one_reg <= t_next;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            x_reg <= sample_in;
        end
        if (state_reg == S_MUL2)
        begin
            acc_reg <= {product[PROD_W-1], product};
        end
        if (state_reg == S_SUM)
        begin
            t_reg <= t_next;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_data_reg <= out_next;
        end
    end

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_MUL1))
        else $error("accepted beat did not start the sequencer");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while sequencer busy");

    a_delay_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |=> (delay_two_reg == $past(delay_one_reg)))
        else $error("delay line did not shift");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && !out_ready) |=>
        ((state_reg == S_OUT) && $stable(out_data_reg)))
        else $error("pending result overwritten");

endmodule
